### design/ryuv_pkg.sv
// shared types and constants for the rgb to yuv 4:2:0 pixel converter
// no dependencies; used by every module of the block
package ryuv_pkg;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_WIDTH = 13;
  localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RST = 13'd480;

  // bt.601 integer weights
  localparam logic [7:0] KY_R = 8'd66;
  localparam logic [7:0] KY_G = 8'd129;
  localparam logic [7:0] KY_B = 8'd25;
  localparam logic [7:0] KU_R = 8'd38;
  localparam logic [7:0] KU_G = 8'd74;
  localparam logic [7:0] KUV_MAIN = 8'd112;
  localparam logic [7:0] KV_G = 8'd94;
  localparam logic [7:0] KV_B = 8'd18;
  localparam logic [16:0] ROUND_BIAS  = 17'd128;
  // rounding bias plus 32768 so the chroma sum never goes negative
  localparam logic [16:0] CHROMA_BIAS = 17'd32896;
  localparam logic [8:0]  LUMA_OFFSET = 9'd16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_value;
    logic       chroma_valid;
    logic       chroma_plane;
    logic       frame_end;
  } res_t;

  // raster position flags of one pixel
  typedef struct packed {
    logic even_col;
    logic odd_row;
    logic last_pix;
  } pos_t;

endpackage

### design/ryuv_pos_cnt.sv
// frame size registers and column / row counters of the converter
// depends on ryuv_pkg
module ryuv_pos_cnt #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [ryuv_pkg::CFG_WIDTH-1:0] cfg_wr_data,
  input  logic                           adv,
  output ryuv_pkg::pos_t                 pos
);

  localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int CH  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WWC = (CW + 1 > ryuv_pkg::CFG_WIDTH) ? CW + 1 : ryuv_pkg::CFG_WIDTH;
  localparam int WWR = (CH + 1 > ryuv_pkg::CFG_WIDTH) ? CH + 1 : ryuv_pkg::CFG_WIDTH;

  logic [ryuv_pkg::CFG_WIDTH-1:0] width_r, height_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [CH-1:0] row_r, row_nxt;
  logic [WWC-1:0] w_ext, w_eff, col_inc;
  logic [WWR-1:0] h_ext, h_eff, row_inc;
  logic last_col, last_row;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ryuv_pkg::FRAME_WIDTH_RST;
      height_r <= ryuv_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ryuv_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_wr_data;
        ryuv_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, clipped to the maximum
  always_comb begin
    w_ext = WWC'(width_r);
    h_ext = WWR'(height_r);
    if (w_ext == '0)                  w_eff = WWC'(1);
    else if (w_ext > WWC'(MAX_WIDTH)) w_eff = WWC'(MAX_WIDTH);
    else                              w_eff = w_ext;
    if (h_ext == '0)                   h_eff = WWR'(1);
    else if (h_ext > WWR'(MAX_HEIGHT)) h_eff = WWR'(MAX_HEIGHT);
    else                               h_eff = h_ext;
  end

  // end of row and frame, also when the size shrank below the counter
  assign col_inc  = WWC'(col_r) + WWC'(1);
  assign row_inc  = WWR'(row_r) + WWR'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[CH-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.even_col = ~col_r[0];
  assign pos.odd_row  = row_r[0];
  assign pos.last_pix = last_col & last_row;

endmodule

### design/ryuv_color.sv
// bt.601 integer color math: luma and the selected chroma sample of one pixel
// depends on ryuv_pkg
module ryuv_color (
  input  ryuv_pkg::pix_t pix,
  input  ryuv_pkg::pos_t pos,
  output ryuv_pkg::res_t res
);

  logic [16:0] r_ext, g_ext, b_ext;
  logic [16:0] y_sum, u_sum, v_sum, c_sum;
  logic [8:0]  y_off;
  logic [7:0]  c_val;

  assign r_ext = 17'(pix.red);
  assign g_ext = 17'(pix.green);
  assign b_ext = 17'(pix.blue);

  // weighted sums; chroma carries a bias so it stays non-negative
  assign y_sum = r_ext * 17'(ryuv_pkg::KY_R) + g_ext * 17'(ryuv_pkg::KY_G)
               + b_ext * 17'(ryuv_pkg::KY_B) + ryuv_pkg::ROUND_BIAS;
  assign u_sum = b_ext * 17'(ryuv_pkg::KUV_MAIN) + ryuv_pkg::CHROMA_BIAS
               - r_ext * 17'(ryuv_pkg::KU_R) - g_ext * 17'(ryuv_pkg::KU_G);
  assign v_sum = r_ext * 17'(ryuv_pkg::KUV_MAIN) + ryuv_pkg::CHROMA_BIAS
               - g_ext * 17'(ryuv_pkg::KV_G) - b_ext * 17'(ryuv_pkg::KV_B);

  // luma: shift, add offset, clamp
  assign y_off = 9'(y_sum[16:8]) + ryuv_pkg::LUMA_OFFSET;

  // chroma: bias and +128 offset cancel, so the shifted sum is the sample
  assign c_sum = pos.odd_row ? v_sum : u_sum;
  assign c_val = c_sum[16] ? 8'hff : c_sum[15:8];

  assign res.luma         = y_off[8] ? 8'hff : y_off[7:0];
  assign res.chroma_value = pos.even_col ? c_val : 8'h00;
  assign res.chroma_valid = pos.even_col;
  assign res.chroma_plane = pos.even_col & pos.odd_row;
  assign res.frame_end    = pos.last_pix;

endmodule

### design/rgb_to_yuv420_pixel_converter.sv
// top level of the rgb to yuv 4:2:0 pixel converter: input and result registers
// depends on ryuv_pkg, ryuv_pos_cnt, ryuv_color
//
// usage:
//   in_data carries one rgb pixel per beat in raster order (valid / stall).
//   out_data carries one result per beat: the pixel's luma, and on even
//   columns one chroma sample (u on even rows, v on odd rows), plus a flag
//   on the last pixel of the frame.
//   cfg_wr_en / cfg_index / cfg_wr_data set frame width (index 0) and frame
//   height (index 1); write only while no pixel is in flight.
// path: an accepted pixel passes the input register, the color math and the result
//   register, in that order, before it shows on out_data.
// throughput: one pixel per clock while out_stall is low, set by the two-stage register pipeline.
// reset: synchronous active-low; size returns to 640 x 480, counters to the
//   top-left pixel, both stages empty.
// stall: when out_stall holds a result, an empty input register still takes
//   one pixel; once it is full it keeps its pixel and in_stall rises; nothing
//   is dropped and a free slot is refilled at once.
module rgb_to_yuv420_pixel_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ryuv_pkg::pix_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ryuv_pkg::res_t                 out_data,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [ryuv_pkg::CFG_WIDTH-1:0] cfg_wr_data
);

  logic           s1_valid_r, s1_valid_nxt;
  ryuv_pkg::pix_t s1_pix_r;
  ryuv_pkg::pos_t s1_pos_r;
  logic           out_valid_r, out_valid_nxt;
  ryuv_pkg::res_t out_data_r;
  ryuv_pkg::pos_t pos;
  ryuv_pkg::res_t res;
  logic           out_free, s1_free, in_acc, s1_move;

  // handshake: each stage moves when the one after it has room
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_move  = s1_valid_r & out_free;
  assign s1_free  = ~s1_valid_r | out_free;
  assign in_stall = ~s1_free;
  assign in_acc   = in_valid & s1_free;

  ryuv_pos_cnt #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos_cnt (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .adv         (in_acc),
    .pos         (pos)
  );

  ryuv_color u_color (
    .pix (s1_pix_r),
    .pos (s1_pos_r),
    .res (res)
  );

  // stage valid bits
  always_comb begin
    s1_valid_nxt  = s1_free ? in_valid : s1_valid_r;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register with the pixel's raster position
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_data;
      s1_pos_r <= pos;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for the rgb to yuv 4:2:0 pixel converter: directed and random pixel beats
// predicts luma, chroma and frame end with its own raster counters; depends on ryuv_pkg
module testbench;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam int QUIET_LIMIT = 4000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  ryuv_pkg::pix_t                 in_data;
  logic                           out_valid;
  logic                           out_stall;
  ryuv_pkg::res_t                 out_data;
  logic                           cfg_wr_en;
  logic                           cfg_index;
  logic [ryuv_pkg::CFG_WIDTH-1:0] cfg_wr_data;

  // predictor state: registers as written, raster position of the next pixel
  logic [ryuv_pkg::CFG_WIDTH-1:0] width_reg;
  logic [ryuv_pkg::CFG_WIDTH-1:0] height_reg;
  int                             col_pos;
  int                             row_pos;
  ryuv_pkg::res_t                 pending_results[$];

  int err_count = 0;
  int stall_pct = 0;
  bit gaps_on = 1'b0;
  int burst_left = 0;
  int hold_cycles = 0;

  rgb_to_yuv420_pixel_converter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_size(input logic [ryuv_pkg::CFG_WIDTH-1:0] reg_val,
                                  input int max_val);
    if (reg_val == '0) return 1;
    return (int'(reg_val) > max_val) ? max_val : int'(reg_val);
  endfunction

  function automatic logic [7:0] clamp8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // bt.601 integer conversion of one pixel, advances the raster counters
  function automatic ryuv_pkg::res_t convert_pixel(input ryuv_pkg::pix_t px);
    ryuv_pkg::res_t r;
    int   w, h, rr, gg, bb, ysum, usum, vsum;
    logic even_col, odd_row, last_col, last_row;
    w  = eff_size(width_reg, MAX_W);
    h  = eff_size(height_reg, MAX_H);
    rr = int'(px.red);
    gg = int'(px.green);
    bb = int'(px.blue);
    ysum = 66 * rr + 129 * gg + 25 * bb + 128;
    usum = -38 * rr - 74 * gg + 112 * bb + 128;
    vsum = 112 * rr - 94 * gg - 18 * bb + 128;
    even_col = (col_pos % 2) == 0;
    odd_row  = (row_pos % 2) == 1;
    last_col = (col_pos + 1) >= w;
    last_row = (row_pos + 1) >= h;
    r.luma = clamp8((ysum >>> 8) + 16);
    if (even_col) begin
      r.chroma_value = odd_row ? clamp8((vsum >>> 8) + 128) : clamp8((usum >>> 8) + 128);
    end else begin
      r.chroma_value = 8'd0;
    end
    r.chroma_valid = even_col;
    r.chroma_plane = even_col && odd_row;
    r.frame_end    = last_col && last_row;
    // counter at or past the last index wraps, even after a shrink
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic ryuv_pkg::pix_t rand_pixel();
    ryuv_pkg::pix_t px;
    px.red   = rand_level();
    px.green = rand_level();
    px.blue  = rand_level();
    return px;
  endfunction

  function automatic int rand_size();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(4097, 8191);
      2: return $urandom_range(17, 64);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // offer one pixel beat and wait until it is taken
  task automatic send_pixel(input ryuv_pkg::pix_t px);
    logic taken;
    in_valid <= 1'b1;
    in_data  <= px;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      if (taken) pending_results.push_back(convert_pixel(px));
      @(posedge clk);
    end
  endtask

  task automatic idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursts of random length with random gaps in between
  task automatic pace();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      idle($urandom_range(1, 10));
    end
  endtask

  task automatic send_pixels(input int n);
    repeat (n) begin
      send_pixel(rand_pixel());
      pace();
    end
  endtask

  // wait until every pending result is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both size registers, written only with the block idle
  task automatic set_frame(input int w, input int h);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= ryuv_pkg::CFG_FRAME_WIDTH;
    cfg_wr_data <= w[ryuv_pkg::CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_index   <= ryuv_pkg::CFG_FRAME_HEIGHT;
    cfg_wr_data <= h[ryuv_pkg::CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    width_reg  = w[ryuv_pkg::CFG_WIDTH-1:0];
    height_reg = h[ryuv_pkg::CFG_WIDTH-1:0];
  endtask

  // ---------------------------------------------------------------- tests

  // reset size 640 x 480 with the primary colors, black, white and magenta
  task automatic test_reset_size();
    ryuv_pkg::pix_t px;
    stall_pct = 30;
    gaps_on   = 1'b1;
    px = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};   send_pixel(px); pace();
    px = '{red: 8'd255, green: 8'd255, blue: 8'd255}; send_pixel(px); pace();
    px = '{red: 8'd255, green: 8'd0,   blue: 8'd0};   send_pixel(px); pace();
    px = '{red: 8'd0,   green: 8'd255, blue: 8'd0};   send_pixel(px); pace();
    px = '{red: 8'd0,   green: 8'd0,   blue: 8'd255}; send_pixel(px); pace();
    px = '{red: 8'd255, green: 8'd0,   blue: 8'd255}; send_pixel(px); pace();
  endtask

  // zero sizes act as one, odd width restarts parity each row
  task automatic test_degenerate_sizes();
    set_frame(0, 0);
    send_pixels(2);
    set_frame(1, 1);
    send_pixels(2);
    set_frame(3, 2);
    send_pixels(6);
  endtask

  // shrink width, then height, while in the middle of a row and frame
  task automatic test_shrink_mid_frame();
    set_frame(20, 10);
    send_pixels(5);
    set_frame(3, 10);
    send_pixels(2);
    set_frame(2, 9);
    send_pixels(6);
    set_frame(2, 2);
    send_pixels(3);
  endtask

  // registers above and at the maximum: short runs, no early wrap
  task automatic test_size_limits();
    stall_pct = 0;
    gaps_on   = 1'b0;
    set_frame(8191, 1);
    send_pixels(8);
    set_frame(1, 4097);
    send_pixels(8);
    set_frame(4096, 4096);
    send_pixels(4);
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    stall_pct = 0;
    gaps_on   = 1'b0;
    set_frame(7, 3);
    hold_cycles = 100;
    send_pixels(40);
  endtask

  // random sizes, random pixels, random idling on both sides after the first phase
  task automatic test_random_frames();
    for (int phase = 0; phase < 6; phase++) begin
      set_frame(rand_size(), rand_size());
      if (phase == 0) begin
        stall_pct = 0;
        gaps_on   = 1'b0;
      end else begin
        stall_pct = (phase == 5) ? 85 : $urandom_range(10, 60);
        gaps_on   = 1'b1;
      end
      // 160 pixels per phase: several whole frames for the smallest sizes, part of a frame otherwise
      send_pixels(160);
    end
  endtask

  // ---------------------------------------------------------------- processes

  // result side stall pattern: random stretches, plus a counted hold-off
  initial begin : result_sink
    int   run_left;
    logic stalling;
    run_left = 0;
    stalling = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 24);
          stalling = ($urandom_range(99) < stall_pct);
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  // compare each result beat with the oldest prediction
  initial begin : result_check
    ryuv_pkg::res_t want;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, luma", -1, out_data.luma);
        end else begin
          want = pending_results.pop_front();
          if (out_data.luma !== want.luma)
            report_mismatch("luma", want.luma, out_data.luma);
          if (out_data.chroma_value !== want.chroma_value)
            report_mismatch("chroma_value", want.chroma_value, out_data.chroma_value);
          if (out_data.chroma_valid !== want.chroma_valid)
            report_mismatch("chroma_valid", want.chroma_valid, out_data.chroma_valid);
          if (out_data.chroma_plane !== want.chroma_plane)
            report_mismatch("chroma_plane", want.chroma_plane, out_data.chroma_plane);
          if (out_data.frame_end !== want.frame_end)
            report_mismatch("frame_end", want.frame_end, out_data.frame_end);
        end
      end
    end
  end

  // end the run when no beat moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  // reset, test sequence and final verdict
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= ryuv_pkg::CFG_FRAME_WIDTH;
    cfg_wr_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    width_reg  = ryuv_pkg::FRAME_WIDTH_RST;
    height_reg = ryuv_pkg::FRAME_HEIGHT_RST;
    col_pos    = 0;
    row_pos    = 0;
    @(posedge clk);

    test_reset_size();
    test_degenerate_sizes();
    test_shrink_mid_frame();
    test_size_limits();
    test_backpressure();
    test_random_frames();

    settle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
